/* rtl/nsp_pkg.sv */
// ----------------------------------------------------------------------------
// nsp_pkg: shared types and constants of the Netpbm stream parser
// Holds the item structs, the parser phase enum and the result codes.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int DIM_BITS_DEFAULT = 16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  sample;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  channels;
    logic [15:0] max_value;
    logic [2:0]  error_code;
    logic        sample_last;
    logic        run_last;
  } out_item_t;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_NUMBER   = 3'd2;
  localparam logic [2:0] ERR_SPACE    = 3'd3;
  localparam logic [2:0] ERR_MISSING  = 3'd4;
  localparam logic [2:0] ERR_DEPTH    = 3'd5;
  localparam logic [2:0] ERR_TRUNC    = 3'd6;

  localparam logic [1:0] FMT_NONE = 2'd0;
  localparam logic [1:0] FMT_P3   = 2'd1;
  localparam logic [1:0] FMT_P6   = 2'd2;
  localparam logic [1:0] FMT_P7   = 2'd3;

  localparam logic [2:0] KW_NONE   = 3'd0;
  localparam logic [2:0] KW_WIDTH  = 3'd1;
  localparam logic [2:0] KW_HEIGHT = 3'd2;
  localparam logic [2:0] KW_DEPTH  = 3'd3;
  localparam logic [2:0] KW_MAXVAL = 3'd4;
  localparam logic [2:0] KW_ENDHDR = 3'd5;

  typedef enum logic [3:0] {
    PH_MAGIC0, PH_MAGIC1, PH_HDR, PH_P6SEP, PH_TOKEN, PH_KEYWORD,
    PH_KNUM, PH_ENDNL, PH_DATA, PH_DONE, PH_ERROR
  } phase_t;

  // Character class computed by the front stage.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_blank;
    logic       is_newline;
    logic       is_hash;
  } class_item_t;

  // Keyword letter at a position; zero past the end of the keyword.
  function automatic logic [7:0] kw_char(input logic [2:0] id, input logic [3:0] pos);
    logic [7:0] c;
    c = 8'd0;
    case (id)
      KW_WIDTH: begin
        case (pos)
          4'd1: c = "I"; 4'd2: c = "D"; 4'd3: c = "T"; 4'd4: c = "H";
          default: c = 8'd0;
        endcase
      end
      KW_HEIGHT: begin
        case (pos)
          4'd1: c = "E"; 4'd2: c = "I"; 4'd3: c = "G"; 4'd4: c = "H"; 4'd5: c = "T";
          default: c = 8'd0;
        endcase
      end
      KW_DEPTH: begin
        case (pos)
          4'd1: c = "E"; 4'd2: c = "P"; 4'd3: c = "T"; 4'd4: c = "H";
          default: c = 8'd0;
        endcase
      end
      KW_MAXVAL: begin
        case (pos)
          4'd1: c = "A"; 4'd2: c = "X"; 4'd3: c = "V"; 4'd4: c = "A"; 4'd5: c = "L";
          default: c = 8'd0;
        endcase
      end
      KW_ENDHDR: begin
        case (pos)
          4'd1: c = "N"; 4'd2: c = "D"; 4'd3: c = "H"; 4'd4: c = "D"; 4'd5: c = "R";
          default: c = 8'd0;
        endcase
      end
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] kw_len(input logic [2:0] id);
    logic [3:0] n;
    case (id)
      KW_WIDTH, KW_DEPTH: n = 4'd5;
      KW_HEIGHT, KW_MAXVAL, KW_ENDHDR: n = 4'd6;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage

/* rtl/netpbm_stream_parser.sv */
// ----------------------------------------------------------------------------
// netpbm_stream_parser: Netpbm P3/P6/P7 byte stream parser
// Checks the magic, parses the header and emits the image samples.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid / in_stall   | in_item  (nsp_pkg::in_item_t)
//   out     | output    | out_valid / out_stall | out_item (nsp_pkg::out_item_t)
//
// A byte first passes through a classifier register, then a two-entry queue,
// then the parser, which writes its zero, one or two results into a two-slot
// output buffer. A byte that yields two results holds the parser while the
// output buffer drains, so the output port sets the pace.
// Reset is synchronous and clears the control state and the parser state.
// A stall on the output backs up through the buffer and the queue to in_stall.
module netpbm_stream_parser #(
  parameter int DIM_BITS = nsp_pkg::DIM_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  nsp_pkg::in_item_t  in_item,
  output logic               in_stall,
  output logic               out_valid,
  output nsp_pkg::out_item_t out_item,
  input  logic               out_stall
);

  // Classified items between the front stage and the queue.
  logic                 f_valid;
  nsp_pkg::class_item_t f_item;
  logic                 f_stall;

  // Queue output towards the parser.
  logic                 q_valid;
  nsp_pkg::class_item_t q_item;
  logic                 q_stall;

  nsp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .cls_valid (f_valid),
    .cls_item  (f_item),
    .cls_stall (f_stall)
  );

  nsp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_item  (f_item),
    .wr_stall (f_stall),
    .rd_valid (q_valid),
    .rd_item  (q_item),
    .rd_stall (q_stall)
  );

  nsp_parser #(
    .DIM_BITS (DIM_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cls_valid (q_valid),
    .cls_item  (q_item),
    .cls_stall (q_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall)
  );

endmodule

/* rtl/nsp_front.sv */
// ----------------------------------------------------------------------------
// nsp_front: byte classifier
// Accepts input bytes into a register stage and tags each with its class.
// ----------------------------------------------------------------------------
module nsp_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  nsp_pkg::in_item_t     in_item,
  output logic                  in_stall,
  output logic                  cls_valid,
  output nsp_pkg::class_item_t  cls_item,
  input  logic                  cls_stall
);

  nsp_pkg::class_item_t cls_next;
  logic [7:0]           b;

  assign in_stall = cls_valid && cls_stall;
  assign b        = in_item.data_byte;

  always_comb begin
    cls_next.data_byte   = b;
    cls_next.end_of_file = in_item.end_of_file;
    cls_next.is_digit    = (b >= "0") && (b <= "9");
    cls_next.digit       = 4'(b - "0");
    cls_next.is_blank    = (b == " ") || (b == 8'h09) || (b == 8'h0d) || (b == 8'h0a);
    cls_next.is_newline  = (b == 8'h0a);
    cls_next.is_hash     = (b == "#");
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cls_valid <= 1'b0;
    end else if (!in_stall) begin
      cls_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      cls_item <= cls_next;
    end
  end

endmodule

/* rtl/nsp_queue.sv */
// ----------------------------------------------------------------------------
// nsp_queue: two-entry queue between the classifier and the parser
// Full-rate, decouples the stall of each side.
// ----------------------------------------------------------------------------
module nsp_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_valid,
  input  nsp_pkg::class_item_t  wr_item,
  output logic                  wr_stall,
  output logic                  rd_valid,
  output nsp_pkg::class_item_t  rd_item,
  input  logic                  rd_stall
);

  nsp_pkg::class_item_t mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           count;
  logic                 push;
  logic                 pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = mem[rd_ptr];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

/* rtl/nsp_parser.sv */
// ----------------------------------------------------------------------------
// nsp_parser: header and sample parser
// Carries out one classified byte per cycle while its output buffer has room,
// and produces up to two results, which leave through a two-slot output buffer.
// ----------------------------------------------------------------------------
module nsp_parser #(
  parameter int DIM_BITS = nsp_pkg::DIM_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cls_valid,
  input  nsp_pkg::class_item_t  cls_item,
  output logic                  cls_stall,
  output logic                  out_valid,
  output nsp_pkg::out_item_t    out_item,
  input  logic                  out_stall
);

  localparam int ACC_BITS = DIM_BITS + 1;
  localparam logic [ACC_BITS-1:0] DIM_MAX = {1'b0, {DIM_BITS{1'b1}}};

  // Parser state.
  nsp_pkg::phase_t       phase, phase_next;
  logic [1:0]            format, format_next;
  logic [ACC_BITS-1:0]   number_accum, number_accum_next;
  logic                  in_number, in_number_next;
  logic                  in_comment, in_comment_next;
  logic                  skipping_line, skipping_line_next;
  logic [2:0]            keyword_id, keyword_id_next;
  logic [3:0]            keyword_pos, keyword_pos_next;
  logic [DIM_BITS-1:0]   width_reg, width_reg_next;
  logic [DIM_BITS-1:0]   height_reg, height_reg_next;
  logic [2:0]            depth_reg, depth_reg_next;
  logic [DIM_BITS-1:0]   maxval_reg, maxval_reg_next;
  logic [3:0]            fields_seen, fields_seen_next;
  logic [DIM_BITS-1:0]   column_count, column_count_next;
  logic [DIM_BITS-1:0]   row_count, row_count_next;
  logic [2:0]            channel_count, channel_count_next;

  // Output buffer: two slots read in order.
  nsp_pkg::out_item_t    obuf [2];
  logic [1:0]            ocnt;
  logic                  ord;

  nsp_pkg::out_item_t    res [2];
  logic [1:0]            nres;
  logic                  take;

  assign cls_stall = (ocnt != 2'd0) && !(ocnt == 2'd1 && !out_stall);
  assign take      = cls_valid && !cls_stall;
  assign out_valid = (ocnt != 2'd0);
  assign out_item  = obuf[ord];

  // Multiply by ten as shifts and adds, then add the digit.
  function automatic logic [ACC_BITS+3:0] times_ten_add(input logic [ACC_BITS-1:0] a,
                                                         input logic [3:0] d);
    logic [ACC_BITS+3:0] w;
    w = {a, 3'b000} + {2'b00, a, 1'b0};
    w = {1'b0, w[ACC_BITS+2:0]} + (ACC_BITS+4)'(d);
    return w;
  endfunction

  always_comb begin : parse
    logic [7:0]          b;
    logic                eof;
    logic                redo;
    logic                finished;
    logic                bad;
    logic [ACC_BITS+3:0] prod;
    logic [ACC_BITS-1:0] v;
    logic [2:0]          ch;
    logic                slast;
    logic [2:0]          kid;
    logic                number_phase;
    logic                ended;

    phase_next         = phase;
    format_next        = format;
    number_accum_next  = number_accum;
    in_number_next     = in_number;
    in_comment_next    = in_comment;
    skipping_line_next = skipping_line;
    keyword_id_next    = keyword_id;
    keyword_pos_next   = keyword_pos;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    depth_reg_next     = depth_reg;
    maxval_reg_next    = maxval_reg;
    fields_seen_next   = fields_seen;
    column_count_next  = column_count;
    row_count_next     = row_count;
    channel_count_next = channel_count;
    nres               = 2'd0;
    res[0]             = '0;
    res[1]             = '0;

    b        = cls_item.data_byte;
    eof      = cls_item.end_of_file;
    redo     = 1'b0;
    finished = 1'b0;
    bad      = 1'b0;
    prod     = '0;
    v        = '0;
    ch       = 3'd0;
    slast    = 1'b0;
    kid      = 3'd0;
    ended    = 1'b0;

    // First pass over the byte. A number ended by this byte completes here;
    // the byte is then looked at again in the phase that follows.
    case (phase)
      nsp_pkg::PH_MAGIC0: begin
        if (b == "P") phase_next = nsp_pkg::PH_MAGIC1;
        else bad = 1'b1;
        if (bad) begin
          res[0] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_MAGIC, default: '0};
          nres = 2'd1;
          phase_next = nsp_pkg::PH_ERROR;
        end
      end
      nsp_pkg::PH_MAGIC1: begin
        if (b == "3") begin
          format_next = nsp_pkg::FMT_P3; depth_reg_next = 3'd3; phase_next = nsp_pkg::PH_HDR;
        end else if (b == "6") begin
          format_next = nsp_pkg::FMT_P6; depth_reg_next = 3'd3; phase_next = nsp_pkg::PH_HDR;
        end else if (b == "7") begin
          format_next = nsp_pkg::FMT_P7; phase_next = nsp_pkg::PH_TOKEN;
        end else begin
          res[0] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_MAGIC, default: '0};
          nres = 2'd1;
          phase_next = nsp_pkg::PH_ERROR;
        end
      end
      nsp_pkg::PH_P6SEP: begin
        if (cls_item.is_blank) begin
          ended = 1'b1;
        end else begin
          res[0] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_SPACE, default: '0};
          nres = 2'd1;
          phase_next = nsp_pkg::PH_ERROR;
        end
      end
      nsp_pkg::PH_ENDNL: begin
        if (cls_item.is_newline) begin
          ended = 1'b1;
        end else begin
          res[0] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_SPACE, default: '0};
          nres = 2'd1;
          phase_next = nsp_pkg::PH_ERROR;
        end
      end
      nsp_pkg::PH_KEYWORD: begin
        if (keyword_id > nsp_pkg::KW_ENDHDR || keyword_pos > 4'd5) begin
          keyword_id_next = nsp_pkg::KW_NONE;
          phase_next = nsp_pkg::PH_TOKEN;
        end else if (b == nsp_pkg::kw_char(keyword_id, keyword_pos)) begin
          keyword_pos_next = keyword_pos + 4'd1;
          if (keyword_pos + 4'd1 >= nsp_pkg::kw_len(keyword_id)) begin
            if (keyword_id == nsp_pkg::KW_ENDHDR) begin
              keyword_id_next = nsp_pkg::KW_NONE;
              if (fields_seen != 4'hf) begin
                res[0] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_MISSING,
                           default: '0};
                nres = 2'd1;
                phase_next = nsp_pkg::PH_ERROR;
              end else if (depth_reg != 3'd3 && depth_reg != 3'd4) begin
                res[0] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_DEPTH,
                           default: '0};
                nres = 2'd1;
                phase_next = nsp_pkg::PH_ERROR;
              end else begin
                phase_next = nsp_pkg::PH_ENDNL;
              end
            end else begin
              in_number_next  = 1'b0;
              in_comment_next = 1'b0;
              phase_next      = nsp_pkg::PH_KNUM;
            end
          end
        end else begin
          keyword_id_next = nsp_pkg::KW_NONE;
          phase_next = nsp_pkg::PH_TOKEN;
          if (!cls_item.is_newline) skipping_line_next = 1'b1;
        end
      end
      nsp_pkg::PH_HDR, nsp_pkg::PH_KNUM, nsp_pkg::PH_DATA: begin
        if (phase == nsp_pkg::PH_DATA && format != nsp_pkg::FMT_P3) begin
          v = ACC_BITS'(b);
          finished = 1'b1;
        end else if (in_number) begin
          if (cls_item.is_digit) begin
            prod = times_ten_add(number_accum, cls_item.digit);
            if (phase == nsp_pkg::PH_DATA) begin
              number_accum_next = ACC_BITS'(prod[7:0]);
            end else if (prod > (ACC_BITS+4)'(DIM_MAX)) begin
              bad = 1'b1;
            end else begin
              number_accum_next = prod[ACC_BITS-1:0];
            end
          end else begin
            in_number_next = 1'b0;
            v = number_accum;
            finished = 1'b1;
            redo = 1'b1;
          end
        end else if (in_comment) begin
          if (cls_item.is_newline) in_comment_next = 1'b0;
        end else if (cls_item.is_digit) begin
          in_number_next = 1'b1;
          number_accum_next = ACC_BITS'(cls_item.digit);
        end else if (cls_item.is_hash) begin
          in_comment_next = 1'b1;
        end else if (!cls_item.is_blank) begin
          bad = 1'b1;
        end
        if (bad) begin
          res[0] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_NUMBER, default: '0};
          nres = 2'd1;
          phase_next = nsp_pkg::PH_ERROR;
        end
      end
      default: begin
      end
    endcase

    // Token phase is handled after the first pass so that a keyword number
    // ended by this byte can start the next token with the same byte.
    // Header numbers and samples are completed here.
    if (finished) begin
      if (phase == nsp_pkg::PH_HDR) begin
        if (fields_seen == 4'd0) width_reg_next = v[DIM_BITS-1:0];
        else if (fields_seen == 4'd1) height_reg_next = v[DIM_BITS-1:0];
        else maxval_reg_next = v[DIM_BITS-1:0];
        fields_seen_next = fields_seen + 4'd1;
        if (fields_seen + 4'd1 >= 4'd3) begin
          if (format == nsp_pkg::FMT_P6) phase_next = nsp_pkg::PH_P6SEP;
          else ended = 1'b1;
        end
      end else if (phase == nsp_pkg::PH_KNUM) begin
        kid = keyword_id;
        if (kid == nsp_pkg::KW_WIDTH) width_reg_next = v[DIM_BITS-1:0];
        else if (kid == nsp_pkg::KW_HEIGHT) height_reg_next = v[DIM_BITS-1:0];
        else if (kid == nsp_pkg::KW_DEPTH) depth_reg_next = (v > ACC_BITS'(7)) ? 3'd7 : v[2:0];
        else maxval_reg_next = v[DIM_BITS-1:0];
        fields_seen_next = fields_seen | (4'd1 << 2'(kid - 3'd1));
        keyword_id_next = nsp_pkg::KW_NONE;
        phase_next = nsp_pkg::PH_TOKEN;
      end else begin
        // Pixel sample.
        ch = (format == nsp_pkg::FMT_P7) ? depth_reg : 3'd3;
        slast = (channel_count + 3'd1 == ch) && (column_count + 1'b1 == width_reg) &&
                (row_count + 1'b1 == height_reg);
        res[0] = '{kind: nsp_pkg::KIND_SAMPLE, sample: v[7:0], sample_last: slast,
                   default: '0};
        nres = 2'd1;
        if (channel_count + 3'd1 >= ch) begin
          channel_count_next = 3'd0;
          if (column_count + 1'b1 >= width_reg) begin
            column_count_next = '0;
            row_count_next = row_count + 1'b1;
          end else begin
            column_count_next = column_count + 1'b1;
          end
        end else begin
          channel_count_next = channel_count + 3'd1;
        end
        if (slast) begin
          phase_next = nsp_pkg::PH_DONE;
          redo = 1'b0;
        end
      end
    end

    if (ended) begin
      res[nres[0]] = '{kind: nsp_pkg::KIND_HEADER, default: '0};
      nres = nres + 2'd1;
      column_count_next  = '0;
      row_count_next     = '0;
      channel_count_next = 3'd0;
      if (width_reg_next == '0 || height_reg_next == '0) phase_next = nsp_pkg::PH_DONE;
      else phase_next = nsp_pkg::PH_DATA;
    end

    // Re-examination of a byte that ended a number. In the data phase a
    // sample ended by a non-digit is looked at again for blanks, comments
    // or the start of the next number.
    if (redo && phase_next == nsp_pkg::PH_DATA) begin
      if (cls_item.is_digit) begin
        in_number_next = 1'b1;
        number_accum_next = ACC_BITS'(cls_item.digit);
      end else if (cls_item.is_hash) begin
        in_comment_next = 1'b1;
      end else if (!cls_item.is_blank) begin
        res[nres[0]] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_NUMBER,
                         default: '0};
        nres = nres + 2'd1;
        phase_next = nsp_pkg::PH_ERROR;
      end
    end else if (redo && phase_next == nsp_pkg::PH_P6SEP) begin
      if (cls_item.is_blank) begin
        res[nres[0]] = '{kind: nsp_pkg::KIND_HEADER, default: '0};
        nres = nres + 2'd1;
        column_count_next  = '0;
        row_count_next     = '0;
        channel_count_next = 3'd0;
        if (width_reg_next == '0 || height_reg_next == '0) phase_next = nsp_pkg::PH_DONE;
        else phase_next = nsp_pkg::PH_DATA;
      end else begin
        res[nres[0]] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_SPACE,
                         default: '0};
        nres = nres + 2'd1;
        phase_next = nsp_pkg::PH_ERROR;
      end
    end else if (redo && phase_next == nsp_pkg::PH_HDR) begin
      if (cls_item.is_digit) begin
        in_number_next = 1'b1;
        number_accum_next = ACC_BITS'(cls_item.digit);
      end else if (cls_item.is_hash) begin
        in_comment_next = 1'b1;
      end else if (!cls_item.is_blank) begin
        res[nres[0]] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_NUMBER,
                         default: '0};
        nres = nres + 2'd1;
        phase_next = nsp_pkg::PH_ERROR;
      end
    end

    // Token phase, reached directly or after a keyword number ended.
    number_phase = (phase == nsp_pkg::PH_TOKEN) || (redo && phase_next == nsp_pkg::PH_TOKEN);
    if (number_phase) begin
      if (skipping_line_next) begin
        if (cls_item.is_newline) skipping_line_next = 1'b0;
      end else if (in_comment_next) begin
        if (cls_item.is_newline) in_comment_next = 1'b0;
      end else if (cls_item.is_blank) begin
      end else if (cls_item.is_hash) begin
        in_comment_next = 1'b1;
      end else begin
        keyword_pos_next = 4'd1;
        phase_next = nsp_pkg::PH_KEYWORD;
        case (b)
          "W": keyword_id_next = nsp_pkg::KW_WIDTH;
          "H": keyword_id_next = nsp_pkg::KW_HEIGHT;
          "D": keyword_id_next = nsp_pkg::KW_DEPTH;
          "M": keyword_id_next = nsp_pkg::KW_MAXVAL;
          "E": keyword_id_next = nsp_pkg::KW_ENDHDR;
          default: begin
            skipping_line_next = 1'b1;
            keyword_pos_next = keyword_pos;
            phase_next = nsp_pkg::PH_TOKEN;
          end
        endcase
      end
    end

    // End of file: finish a pending number, then flag truncation.
    if (eof) begin
      if (in_number_next && (phase_next == nsp_pkg::PH_HDR || phase_next == nsp_pkg::PH_KNUM ||
                             phase_next == nsp_pkg::PH_DATA)) begin
        v = number_accum_next;
        if (phase_next == nsp_pkg::PH_HDR) begin
          if (fields_seen_next == 4'd0) width_reg_next = v[DIM_BITS-1:0];
          else if (fields_seen_next == 4'd1) height_reg_next = v[DIM_BITS-1:0];
          else maxval_reg_next = v[DIM_BITS-1:0];
          if (fields_seen_next + 4'd1 >= 4'd3) begin
            if (format_next == nsp_pkg::FMT_P6) begin
              phase_next = nsp_pkg::PH_P6SEP;
            end else begin
              res[nres[0]] = '{kind: nsp_pkg::KIND_HEADER, default: '0};
              nres = nres + 2'd1;
              if (width_reg_next == '0 || height_reg_next == '0) phase_next = nsp_pkg::PH_DONE;
              else phase_next = nsp_pkg::PH_DATA;
            end
          end
        end else if (phase_next == nsp_pkg::PH_KNUM) begin
          // The field is still stored so that the error result shows it.
          if (keyword_id_next == nsp_pkg::KW_WIDTH) width_reg_next = v[DIM_BITS-1:0];
          else if (keyword_id_next == nsp_pkg::KW_HEIGHT) height_reg_next = v[DIM_BITS-1:0];
          else if (keyword_id_next == nsp_pkg::KW_DEPTH)
            depth_reg_next = (v > ACC_BITS'(7)) ? 3'd7 : v[2:0];
          else maxval_reg_next = v[DIM_BITS-1:0];
          phase_next = nsp_pkg::PH_TOKEN;
        end else begin
          ch = (format_next == nsp_pkg::FMT_P7) ? depth_reg_next : 3'd3;
          slast = (channel_count_next + 3'd1 == ch) &&
                  (column_count_next + 1'b1 == width_reg_next) &&
                  (row_count_next + 1'b1 == height_reg_next);
          res[nres[0]] = '{kind: nsp_pkg::KIND_SAMPLE, sample: v[7:0], sample_last: slast,
                           default: '0};
          nres = nres + 2'd1;
          if (slast) phase_next = nsp_pkg::PH_DONE;
        end
      end
      if (phase_next != nsp_pkg::PH_DONE && phase_next != nsp_pkg::PH_ERROR) begin
        res[nres[0]] = '{kind: nsp_pkg::KIND_ERROR, error_code: nsp_pkg::ERR_TRUNC,
                         default: '0};
        nres = nres + 2'd1;
      end
    end

    // Fill in the register view, which reflects state at the time of each result.
    // The view is the state after this byte; fields set by the same byte before a
    // result are the same ones the result sees.
    for (int i = 0; i < 2; i++) begin
      res[i].image_width  = 16'(width_reg_next);
      res[i].image_height = 16'(height_reg_next);
      res[i].channels     = (format_next == nsp_pkg::FMT_P7) ? depth_reg_next :
                            ((format_next == nsp_pkg::FMT_NONE) ? 3'd0 : 3'd3);
      res[i].max_value    = 16'(maxval_reg_next);
      res[i].run_last     = (2'(i) + 2'd1 == nres);
    end

    if (eof) begin
      phase_next         = nsp_pkg::PH_MAGIC0;
      format_next        = nsp_pkg::FMT_NONE;
      number_accum_next  = '0;
      in_number_next     = 1'b0;
      in_comment_next    = 1'b0;
      skipping_line_next = 1'b0;
      keyword_id_next    = nsp_pkg::KW_NONE;
      keyword_pos_next   = 4'd0;
      width_reg_next     = '0;
      height_reg_next    = '0;
      depth_reg_next     = 3'd0;
      maxval_reg_next    = '0;
      fields_seen_next   = 4'd0;
      column_count_next  = '0;
      row_count_next     = '0;
      channel_count_next = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= nsp_pkg::PH_MAGIC0;
      format        <= nsp_pkg::FMT_NONE;
      number_accum  <= '0;
      in_number     <= 1'b0;
      in_comment    <= 1'b0;
      skipping_line <= 1'b0;
      keyword_id    <= nsp_pkg::KW_NONE;
      keyword_pos   <= 4'd0;
      width_reg     <= '0;
      height_reg    <= '0;
      depth_reg     <= 3'd0;
      maxval_reg    <= '0;
      fields_seen   <= 4'd0;
      column_count  <= '0;
      row_count     <= '0;
      channel_count <= 3'd0;
    end else if (take) begin
      phase         <= phase_next;
      format        <= format_next;
      number_accum  <= number_accum_next;
      in_number     <= in_number_next;
      in_comment    <= in_comment_next;
      skipping_line <= skipping_line_next;
      keyword_id    <= keyword_id_next;
      keyword_pos   <= keyword_pos_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      depth_reg     <= depth_reg_next;
      maxval_reg    <= maxval_reg_next;
      fields_seen   <= fields_seen_next;
      column_count  <= column_count_next;
      row_count     <= row_count_next;
      channel_count <= channel_count_next;
    end
  end

  // Output buffer control: a new byte is taken only when at most the last
  // buffered result is leaving, so both slots are free for its results.
  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
      ord  <= 1'b0;
    end else if (take) begin
      ocnt <= nres;
      ord  <= 1'b0;
    end else if (out_valid && !out_stall) begin
      ocnt <= ocnt - 2'd1;
      ord  <= ~ord;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      obuf[0] <= res[0];
      obuf[1] <= res[1];
    end
  end

endmodule
